>>> hw/rtl/can_signal_extract_pack_defines.svh
// Assertion macros used by the signal extract / pack RTL.
`ifndef CAN_SIGNAL_EXTRACT_PACK_DEFINES_SVH
`define CAN_SIGNAL_EXTRACT_PACK_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define CSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cse_pkg.sv
package cse_pkg;

    localparam int PAYLOAD_BYTES = 8;

    // Payload bytes at index PAYLOAD_BYTES and above sit in the low bits of the word.
    localparam logic [63:0] PAY_MASK = ~64'd0 << (8 * (8 - PAYLOAD_BYTES));

    localparam logic [6:0]  MAX_LEN  = 7'd64;
    localparam logic [63:0] PHYS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PHYS_MIN = 64'h8000_0000_0000_0000;

    localparam logic [5:0]  RST_START_BIT      = 6'd0;
    localparam logic [6:0]  RST_SIGNAL_LENGTH  = 7'd8;
    localparam logic [31:0] RST_SCALE_FACTOR   = 32'h0001_0000;
    localparam logic [63:0] RST_SCALE_OFFSET   = 64'd0;
    localparam logic [31:0] RST_INVERSE_FACTOR = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_START_BIT      = 3'd0,
        REG_SIGNAL_LENGTH  = 3'd1,
        REG_BYTE_ORDER     = 3'd2,
        REG_SCALE_FACTOR   = 3'd3,
        REG_SCALE_OFFSET   = 3'd4,
        REG_INVERSE_FACTOR = 3'd5
    } t_reg_idx;

    typedef enum logic {
        CMD_DECODE = 1'b0,
        CMD_ENCODE = 1'b1
    } t_cmd;

    typedef enum logic {
        ORDER_MOTOROLA = 1'b0,
        ORDER_INTEL    = 1'b1
    } t_order;

    localparam t_order RST_BYTE_ORDER = ORDER_INTEL;

    // Per-stage control that travels alongside the operands.
    typedef struct packed {
        logic vld;
        t_cmd cmd;
        logic neg;
    } t_ctl;

    // Swap byte order: payload byte b moves to little-endian byte b.
    function automatic logic [63:0] cse_bswap(input logic [63:0] v);
        logic [63:0] r;
        for (int b = 0; b < 8; b++) begin
            r[8*b +: 8] = v[8*(7-b) +: 8];
        end
        return r;
    endfunction

    // Pull a field out of the payload. For Motorola, t is the sequential first bit.
    function automatic logic [63:0] cse_extract(input logic [63:0] payload,
                                                input logic [5:0]  t,
                                                input logic [6:0]  len,
                                                input logic [63:0] mask,
                                                input t_order      order);
        logic [63:0] p;
        logic [6:0]  sh;
        logic [63:0] v;
        p  = payload & PAY_MASK;
        sh = {1'b0, t} + len;
        if (order == ORDER_INTEL) begin
            v = cse_bswap(p) >> t;
        end else if (sh <= MAX_LEN) begin
            v = p >> (MAX_LEN - sh);
        end else begin
            v = p << (sh - MAX_LEN);
        end
        return v & mask;
    endfunction

    // Place a field into an otherwise zero payload; bits past the payload drop.
    function automatic logic [63:0] cse_place(input logic [63:0] raw,
                                              input logic [5:0]  t,
                                              input logic [6:0]  len,
                                              input logic [63:0] mask,
                                              input t_order      order);
        logic [63:0] f;
        logic [6:0]  sh;
        logic [63:0] v;
        f  = raw & mask;
        sh = {1'b0, t} + len;
        if (order == ORDER_INTEL) begin
            v = cse_bswap(f << t);
        end else if (sh <= MAX_LEN) begin
            v = f << (MAX_LEN - sh);
        end else begin
            v = f >> (sh - MAX_LEN);
        end
        return v & PAY_MASK;
    endfunction

endpackage

>>> hw/rtl/cse_mul.sv
module cse_mul
    import cse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  logic [63:0] i_a,
    input  logic [31:0] i_m,
    output t_ctl        o_ctl,
    output logic [95:0] o_mag
);

    // 64 x 32 unsigned product as two 32 x 32 partial products, summed a stage later.
    t_ctl        r_pp_ctl;
    logic [63:0] r_pp_lo;
    logic [63:0] r_pp_hi;
    t_ctl        r_mag_ctl;
    logic [95:0] r_mag;
    logic [95:0] n_mag;

    assign n_mag = {r_pp_hi, 32'd0} + {32'd0, r_pp_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_ctl  <= '0;
            r_mag_ctl <= '0;
        end else begin
            r_pp_ctl  <= i_ctl;
            r_mag_ctl <= r_pp_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp_lo <= {32'd0, i_a[31:0]} * {32'd0, i_m};
        r_pp_hi <= {32'd0, i_a[63:32]} * {32'd0, i_m};
        r_mag   <= n_mag;
    end

    assign o_ctl = r_mag_ctl;
    assign o_mag = r_mag;

endmodule

>>> hw/rtl/can_signal_extract_pack.sv
// Signal extract / pack for one DBC signal in an 8-byte CAN payload.
//
// Request channel: start is sampled with i_cmd, i_payload_in and i_physical_in; a request
// is taken at a rising edge where start is high and busy is low. busy is low whenever
// the block is out of reset, so a request can be taken in every cycle.
// Decode (CMD_DECODE) returns the raw field and raw * factor + offset in Q48.16,
// saturated and flagged. Encode (CMD_ENCODE) returns trunc((phys - offset) * inverse),
// clamped to the field range and flagged, and the payload with those bits placed.
// Result channel: o_done is high for one cycle with the result on the o_ ports, once the
// request has passed the input register, the operand stage, two multiplier stages, the
// arithmetic stage and the placement/output register.
// Throughput is one request per cycle; the shared 64 x 32 multiplier is split into two
// 32 x 32 partial products, which sets the depth. The receiver cannot stall results.
// Configuration: write register i_cfg_index with i_cfg_data when i_cfg_valid and
// o_cfg_ready are high; indexes past the list are ignored. Write only while idle.
// Reset (synchronous, active low) restores the register defaults and drops every
// request in flight; busy is high and o_cfg_ready low while reset is held.
`include "can_signal_extract_pack_defines.svh"

module can_signal_extract_pack
    import cse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [63:0]        i_payload_in,
    input  logic signed [63:0] i_physical_in,
    output logic               o_done,
    output logic signed [63:0] o_physical_out,
    output logic [63:0]        o_raw_value,
    output logic [63:0]        o_payload_out,
    output logic               o_out_of_range,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    // Configuration registers
    logic [5:0]         r_start_bit;
    logic [6:0]         r_signal_length;
    t_order             r_byte_order;
    logic signed [31:0] r_scale_factor;
    logic signed [63:0] r_scale_offset;
    logic signed [31:0] r_inverse_factor;

    // Derived field geometry; the user holds it static while requests are in flight.
    logic [6:0]  w_len;
    logic [5:0]  w_first;
    logic [63:0] w_mask;

    logic w_accept;
    logic w_cfg_we;

    // Input register
    logic               r_s1_vld;
    t_cmd               r_s1_cmd;
    logic [63:0]        r_s1_payload;
    logic signed [63:0] r_s1_phys;

    // Operand stage
    logic [63:0] n_raw_dec;
    logic        n_dneg;
    logic [63:0] n_dmag;
    logic        w_fneg;
    logic [31:0] w_fmag;
    logic        w_vneg;
    logic [31:0] w_vmag;
    t_ctl        n_s2_ctl;
    logic [63:0] n_s2_a;
    logic [31:0] n_s2_m;
    t_ctl        r_s2_ctl;
    logic [63:0] r_s2_a;
    logic [31:0] r_s2_m;

    // Raw field delayed alongside the multiplier
    logic [63:0] r_s3_raw;
    logic [63:0] r_s4_raw;

    t_ctl        w_mag_ctl;
    logic [95:0] w_mag;

    // Arithmetic stage
    logic [97:0] w_off_x;
    logic [97:0] w_mag_x;
    logic [97:0] n_sum;
    logic        n_fits;
    logic [63:0] n_ip;
    logic [63:0] n_s5_phys;
    logic [63:0] n_s5_raw;
    logic        n_s5_flag;
    logic        r_s5_vld;
    t_cmd        r_s5_cmd;
    logic [63:0] r_s5_phys;
    logic [63:0] r_s5_raw;
    logic        r_s5_flag;

    // Output register
    logic [63:0] n_pay;
    logic        r_out_vld;
    t_cmd        r_out_cmd;
    logic [63:0] r_out_phys;
    logic [63:0] r_out_raw;
    logic [63:0] r_out_pay;
    logic        r_out_flag;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = start & ~busy;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;

    // Lengths past 64 act as 64; Motorola start bit maps to the sequential numbering.
    assign w_len   = (r_signal_length > MAX_LEN) ? MAX_LEN : r_signal_length;
    assign w_first = (r_byte_order == ORDER_INTEL) ? r_start_bit : (r_start_bit ^ 6'd7);
    assign w_mask  = (64'd1 << w_len) - 64'd1;

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bit      <= RST_START_BIT;
            r_signal_length  <= RST_SIGNAL_LENGTH;
            r_byte_order     <= RST_BYTE_ORDER;
            r_scale_factor   <= RST_SCALE_FACTOR;
            r_scale_offset   <= RST_SCALE_OFFSET;
            r_inverse_factor <= RST_INVERSE_FACTOR;
        end else if (w_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_START_BIT:      r_start_bit      <= i_cfg_data[5:0];
                REG_SIGNAL_LENGTH:  r_signal_length  <= i_cfg_data[6:0];
                REG_BYTE_ORDER:     r_byte_order     <= t_order'(i_cfg_data[0]);
                REG_SCALE_FACTOR:   r_scale_factor   <= i_cfg_data[31:0];
                REG_SCALE_OFFSET:   r_scale_offset   <= i_cfg_data;
                REG_INVERSE_FACTOR: r_inverse_factor <= i_cfg_data[31:0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- operand stage
    // Decode: extract the raw field, multiply by |factor|.
    // Encode: |phys - offset| times |inverse|; sign kept aside for both.
    assign n_raw_dec = cse_extract(r_s1_payload, w_first, w_len, w_mask, r_byte_order);
    assign n_dneg    = r_s1_phys < r_scale_offset;
    assign n_dmag    = n_dneg ? 64'(r_scale_offset - r_s1_phys)
                              : 64'(r_s1_phys - r_scale_offset);
    assign w_fneg    = r_scale_factor[31];
    assign w_fmag    = w_fneg ? 32'(32'd0 - r_scale_factor) : 32'(r_scale_factor);
    assign w_vneg    = r_inverse_factor[31];
    assign w_vmag    = w_vneg ? 32'(32'd0 - r_inverse_factor) : 32'(r_inverse_factor);

    always_comb begin
        n_s2_ctl.vld = r_s1_vld;
        n_s2_ctl.cmd = r_s1_cmd;
        if (r_s1_cmd == CMD_ENCODE) begin
            n_s2_ctl.neg = n_dneg ^ w_vneg;
            n_s2_a       = n_dmag;
            n_s2_m       = w_vmag;
        end else begin
            n_s2_ctl.neg = w_fneg;
            n_s2_a       = n_raw_dec;
            n_s2_m       = w_fmag;
        end
    end

    cse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s2_ctl),
        .i_a     (r_s2_a),
        .i_m     (r_s2_m),
        .o_ctl   (w_mag_ctl),
        .o_mag   (w_mag)
    );

    // ---------------------------------------------------------------- arithmetic stage
    // Decode: offset -/+ magnitude in 98 bits, then saturate to 64 signed bits.
    assign w_off_x = {{34{r_scale_offset[63]}}, r_scale_offset};
    assign w_mag_x = {2'b00, w_mag};
    assign n_sum   = w_mag_ctl.neg ? (w_off_x - w_mag_x) : (w_off_x + w_mag_x);
    assign n_fits  = (n_sum[97:63] == '0) || (n_sum[97:63] == '1);

    // Encode: drop the 32 fraction bits (truncation toward zero on the magnitude).
    assign n_ip = w_mag[95:32];

    always_comb begin
        n_s5_phys = '0;
        n_s5_raw  = r_s4_raw;
        n_s5_flag = 1'b0;
        if (w_mag_ctl.cmd == CMD_ENCODE) begin
            if (w_mag_ctl.neg) begin
                // clamp any negative result to zero
                n_s5_raw  = '0;
                n_s5_flag = (n_ip != '0);
            end else if (n_ip > w_mask) begin
                n_s5_raw  = w_mask;
                n_s5_flag = 1'b1;
            end else begin
                n_s5_raw  = n_ip;
            end
        end else if (n_fits) begin
            n_s5_phys = n_sum[63:0];
        end else begin
            n_s5_phys = n_sum[97] ? PHYS_MIN : PHYS_MAX;
            n_s5_flag = 1'b1;
        end
    end

    // ---------------------------------------------------------------- placement stage
    assign n_pay = (r_s5_cmd == CMD_ENCODE)
                 ? cse_place(r_s5_raw, w_first, w_len, w_mask, r_byte_order) : '0;

    // ---------------------------------------------------------------- pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_ctl  <= '0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= w_accept;
            r_s2_ctl  <= n_s2_ctl;
            r_s5_vld  <= w_mag_ctl.vld;
            r_out_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd     <= t_cmd'(i_cmd);
            r_s1_payload <= i_payload_in;
            r_s1_phys    <= i_physical_in;
        end
        r_s2_a     <= n_s2_a;
        r_s2_m     <= n_s2_m;
        r_s3_raw   <= r_s2_a;
        r_s4_raw   <= r_s3_raw;
        r_s5_cmd   <= w_mag_ctl.cmd;
        r_s5_phys  <= n_s5_phys;
        r_s5_raw   <= n_s5_raw;
        r_s5_flag  <= n_s5_flag;
        r_out_cmd  <= r_s5_cmd;
        r_out_phys <= r_s5_phys;
        r_out_raw  <= r_s5_raw;
        r_out_pay  <= n_pay;
        r_out_flag <= r_s5_flag;
    end

    assign o_done         = r_out_vld;
    assign o_physical_out = r_out_phys;
    assign o_raw_value    = r_out_raw;
    assign o_payload_out  = r_out_pay;
    assign o_out_of_range = r_out_flag;

    // ---------------------------------------------------------------- checks
    `CSE_ASSERT_SAME(a_done_has_request, i_clk, i_rst_n, o_done, $past(w_accept, 6), "result without request")
    `CSE_ASSERT_SAME(a_decode_no_payload, i_clk, i_rst_n, o_done && (r_out_cmd == CMD_DECODE), o_payload_out == '0, "decode result carries payload bits")
    `CSE_ASSERT_SAME(a_encode_no_phys, i_clk, i_rst_n, o_done && (r_out_cmd == CMD_ENCODE), o_physical_out == '0, "encode result carries a physical value")
    `CSE_ASSERT_SAME(a_encode_in_field, i_clk, i_rst_n, o_done && (r_out_cmd == CMD_ENCODE), (o_raw_value & ~w_mask) == '0, "encoded raw value exceeds field")
    `CSE_ASSERT_SAME(a_decode_sat_bound, i_clk, i_rst_n, o_done && (r_out_cmd == CMD_DECODE) && o_out_of_range, (r_out_phys == PHYS_MIN) || (r_out_phys == PHYS_MAX), "saturated decode not at a bound")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

// Check the DBC signal extract / pack block against a predictor kept in this file:
// directed requests on the layout corners, saturation, clamping and the odd lengths,
// then random traffic over many register settings with random gaps on the request side.

module testbench;
    import cse_pkg::*;

    localparam int RESULT_LATENCY       = 5;
    localparam int RANDOM_SETTINGS      = 17;
    localparam int REQUESTS_PER_SETTING = 100;
    localparam int MAX_MISMATCH_LINES   = 100;

    typedef struct {
        logic [63:0] phys;
        logic [63:0] raw;
        logic [63:0] pay;
        logic        flag;
    } t_signal_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cmd = 1'b0;
    logic [63:0]        i_payload_in = '0;
    logic signed [63:0] i_physical_in = '0;
    logic               o_done;
    logic signed [63:0] o_physical_out;
    logic [63:0]        o_raw_value;
    logic [63:0]        o_payload_out;
    logic               o_out_of_range;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [63:0]        i_cfg_data = '0;

    // Own copy of the signal registers, updated on every accepted write.
    logic [5:0]  sig_start   = RST_START_BIT;
    logic [6:0]  sig_length  = RST_SIGNAL_LENGTH;
    t_order      sig_order   = RST_BYTE_ORDER;
    logic [31:0] sig_factor  = RST_SCALE_FACTOR;
    logic [63:0] sig_offset  = RST_SCALE_OFFSET;
    logic [31:0] sig_inverse = RST_INVERSE_FACTOR;

    t_signal_result pending_results[$];
    t_signal_result head_result;

    int mismatch_count = 0;
    int n_decode       = 0;
    int n_encode       = 0;
    int n_flagged      = 0;
    int n_settings     = 1;
    int no_gap_run     = 0;

    can_signal_extract_pack u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_payload_in   (i_payload_in),
        .i_physical_in  (i_physical_in),
        .o_done         (o_done),
        .o_physical_out (o_physical_out),
        .o_raw_value    (o_raw_value),
        .o_payload_out  (o_payload_out),
        .o_out_of_range (o_out_of_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or never answers.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] field_mask(int unsigned len);
        if (len == 0) return '0;
        if (len >= 64) return '1;
        return (64'd1 << len) - 64'd1;
    endfunction

    // Map a sequential (Motorola) or Intel bit number to its position in the
    // payload word; -1 when it falls past the last payload byte.
    function automatic int payload_pos(int unsigned n, t_order order);
        int unsigned byte_no;
        int unsigned bit_no;
        byte_no = n / 8;
        bit_no  = n % 8;
        if (byte_no >= PAYLOAD_BYTES) return -1;
        if (order == ORDER_MOTOROLA) bit_no = 7 - bit_no;
        return (7 - byte_no) * 8 + bit_no;
    endfunction

    function automatic t_signal_result compute_signal_result(t_cmd cmd, logic [63:0] payload,
                                                             logic signed [63:0] physical);
        t_signal_result      r;
        int unsigned         len;
        int unsigned         s;
        int unsigned         first_seq;
        int unsigned         rb;
        int                  pos;
        logic signed [127:0] exact;
        logic signed [64:0]  diff;
        logic [63:0]         dmag;
        logic [31:0]         imag;
        logic [127:0]        prod;
        logic [63:0]         whole;
        logic [63:0]         fmax;
        logic                neg;
        r.phys = '0;
        r.raw  = '0;
        r.pay  = '0;
        r.flag = 1'b0;
        len  = (sig_length > 7'd64) ? 64 : sig_length;
        fmax = field_mask(len);
        s    = sig_start;
        // Motorola start bits count inside the byte from the top: translate to
        // the sequential numbering first.
        first_seq = (sig_order == ORDER_INTEL) ? s : (s / 8) * 8 + 7 - s % 8;

        if (cmd == CMD_DECODE) begin
            for (int i = 0; i < len; i++) begin
                pos = payload_pos(first_seq + i, sig_order);
                rb  = (sig_order == ORDER_INTEL) ? i : len - 1 - i;
                if (pos >= 0) begin
                    if (payload[pos]) r.raw[rb] = 1'b1;
                end
            end
            exact = $signed({64'd0, r.raw}) * $signed({{96{sig_factor[31]}}, sig_factor})
                  + $signed({{64{sig_offset[63]}}, sig_offset});
            if (exact[127:63] == '0 || exact[127:63] == '1) begin
                r.phys = exact[63:0];
            end else begin
                r.phys = exact[127] ? PHYS_MIN : PHYS_MAX;
                r.flag = 1'b1;
            end
        end else begin
            // Work in magnitudes: the exact product is Q.32, truncate toward zero.
            diff  = $signed({physical[63], physical}) - $signed({sig_offset[63], sig_offset});
            dmag  = diff[64] ? (~diff[63:0] + 64'd1) : diff[63:0];
            imag  = sig_inverse[31] ? (~sig_inverse + 32'd1) : sig_inverse;
            prod  = {64'd0, dmag} * {96'd0, imag};
            whole = prod[95:32];
            neg   = diff[64] ^ sig_inverse[31];
            if (neg && whole != '0) begin
                r.raw  = '0;
                r.flag = 1'b1;
            end else if (!neg && whole > fmax) begin
                r.raw  = fmax;
                r.flag = 1'b1;
            end else begin
                r.raw = neg ? '0 : whole;
            end
            for (int i = 0; i < len; i++) begin
                pos = payload_pos(first_seq + i, sig_order);
                rb  = (sig_order == ORDER_INTEL) ? i : len - 1 - i;
                if (pos >= 0) begin
                    if (r.raw[rb]) r.pay[pos] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            if (mismatch_count < MAX_MISMATCH_LINES) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
            mismatch_count++;
        end
    endfunction

    // Compare every strobed result against the oldest outstanding request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (o_out_of_range) n_flagged++;
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_MISMATCH_LINES) begin
                    $display("%0t: result with no request outstanding, expected none, actual %h %h %h %b",
                             $time, o_physical_out, o_raw_value, o_payload_out, o_out_of_range);
                end
                mismatch_count++;
            end else begin
                head_result = pending_results.pop_front();
                check_field("physical_out", head_result.phys, o_physical_out);
                check_field("raw_value", head_result.raw, o_raw_value);
                check_field("payload_out", head_result.pay, o_payload_out);
                check_field("out_of_range", {63'd0, head_result.flag}, {63'd0, o_out_of_range});
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // Drive one request, hold it until taken, then record what it must return.
    task automatic send_request(t_cmd cmd, logic [63:0] payload, logic [63:0] physical);
        int gap;
        if (no_gap_run > 0) begin
            gap = 0;
            no_gap_run--;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0) no_gap_run = $urandom_range(10, 40);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         = 1'b1;
        i_cmd         = cmd;
        i_payload_in  = payload;
        i_physical_in = physical;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(compute_signal_result(cmd, payload, physical));
        if (cmd == CMD_DECODE) n_decode++;
        else n_encode++;
    endtask

    // Drop start and let every outstanding request come back before touching registers.
    task automatic wait_for_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg_idx idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_START_BIT:      sig_start   = value[5:0];
            REG_SIGNAL_LENGTH:  sig_length  = value[6:0];
            REG_BYTE_ORDER:     sig_order   = t_order'(value[0]);
            REG_SCALE_FACTOR:   sig_factor  = value[31:0];
            REG_SCALE_OFFSET:   sig_offset  = value;
            REG_INVERSE_FACTOR: sig_inverse = value[31:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [5:0] start_bit, logic [6:0] length, t_order order,
                             logic [31:0] factor, logic [63:0] offset, logic [31:0] inverse);
        wait_for_results();
        write_register(REG_START_BIT, {58'd0, start_bit});
        write_register(REG_SIGNAL_LENGTH, {57'd0, length});
        write_register(REG_BYTE_ORDER, {63'd0, order});
        write_register(REG_SCALE_FACTOR, {32'd0, factor});
        write_register(REG_SCALE_OFFSET, offset);
        write_register(REG_INVERSE_FACTOR, {32'd0, inverse});
        n_settings++;
    endtask

    // ---------------------------------------------------------------- tests

    // Defaults: Intel byte 0, unit factor and inverse, no offset.
    task automatic test_reset_defaults();
        send_request(CMD_DECODE, '1, '0);
        send_request(CMD_DECODE, '0, '0);
        send_request(CMD_ENCODE, '0, 64'sd5 <<< 16);
        send_request(CMD_ENCODE, '1, PHYS_MIN);
        send_request(CMD_ENCODE, '0, PHYS_MAX);
    endtask

    // Intel fields: top start bit with most of the field past the payload, then a
    // field spanning three bytes.
    task automatic test_intel_layout();
        configure(6'd63, 7'd64, ORDER_INTEL, 32'h0001_0000, '0, 32'h0001_0000);
        send_request(CMD_DECODE, '1, '0);
        send_request(CMD_ENCODE, '0, 64'sd3 <<< 16);
        configure(6'd12, 7'd20, ORDER_INTEL, 32'h0001_0000, '0, 32'h0001_0000);
        send_request(CMD_DECODE, 64'h0123_4567_89AB_CDEF, '0);
    endtask

    // Motorola fields: whole word, a byte-crossing field, and one running off the end.
    task automatic test_motorola_layout();
        configure(6'd7, 7'd64, ORDER_MOTOROLA, 32'h0001_0000, '0, 32'h0001_0000);
        send_request(CMD_DECODE, 64'h0123_4567_89AB_CDEF, '0);
        send_request(CMD_ENCODE, '0, PHYS_MAX);
        configure(6'd0, 7'd16, ORDER_MOTOROLA, 32'h0001_0000, '0, 32'h0001_0000);
        send_request(CMD_DECODE, 64'hA5C3_0000_0000_0000, '0);
        configure(6'd60, 7'd12, ORDER_MOTOROLA, 32'h0001_0000, '0, 32'h0001_0000);
        send_request(CMD_DECODE, '1, '0);
        send_request(CMD_ENCODE, '0, 64'sh0FFF_0000);
    endtask

    // Decode overflow in both directions, from the factor and from the offset.
    task automatic test_decode_saturation();
        configure(6'd0, 7'd64, ORDER_INTEL, 32'h8000_0000, '0, 32'h0001_0000);
        send_request(CMD_DECODE, '1, '0);
        configure(6'd0, 7'd64, ORDER_INTEL, 32'h7FFF_FFFF, '0, 32'h0001_0000);
        send_request(CMD_DECODE, '1, '0);
        configure(6'd0, 7'd64, ORDER_INTEL, 32'h0001_0000, PHYS_MAX, 32'h0001_0000);
        send_request(CMD_DECODE, 64'h0100_0000_0000_0000, '0);
        configure(6'd0, 7'd64, ORDER_INTEL, 32'hFFFF_FFFF, PHYS_MIN, 32'h0001_0000);
        send_request(CMD_DECODE, 64'h0100_0000_0000_0000, '0);
    endtask

    // Encode: a clamp above the field, a zero difference, a tiny negative truncated to zero.
    task automatic test_encode_clamp();
        configure(6'd0, 7'd8, ORDER_INTEL, 32'h0001_0000, PHYS_MAX, 32'h8000_0000);
        send_request(CMD_ENCODE, '0, PHYS_MIN);
        send_request(CMD_ENCODE, '0, PHYS_MAX);
        configure(6'd0, 7'd8, ORDER_INTEL, 32'h0001_0000, '0, 32'h0001_0000);
        send_request(CMD_ENCODE, '0, -64'sd1);
    endtask

    // Empty field, and a length register above 64 that behaves as 64.
    task automatic test_length_edges();
        configure(6'd5, 7'd0, ORDER_INTEL, 32'h0001_0000, '0, 32'h0001_0000);
        send_request(CMD_DECODE, '1, '0);
        send_request(CMD_ENCODE, '0, 64'sd5 <<< 16);
        configure(6'd7, 7'd127, ORDER_MOTOROLA, 32'h0001_0000, '0, 32'h0001_0000);
        send_request(CMD_DECODE, '1, '0);
        send_request(CMD_ENCODE, '1, PHYS_MAX);
    endtask

    // Q16.16 value: unit, small of either sign, anything, or an extreme.
    function automatic logic [31:0] random_q16();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = 32'h0001_0000;
            1: begin
                v = $urandom_range(0, 32'h0004_0000);
                if ($urandom_range(0, 1) == 1) v = ~v + 32'd1;
            end
            2: v = $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic test_random_traffic();
        logic [6:0]  len_cfg;
        logic [63:0] offset;
        logic [63:0] fmax;
        logic [63:0] span;
        logic [63:0] payload;
        logic [63:0] phys;
        t_cmd        cmd;
        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            case ($urandom_range(0, 9))
                0: len_cfg = 7'd1;
                1: len_cfg = 7'd64;
                2: len_cfg = ($urandom_range(0, 1) == 1) ? 7'd0 : 7'($urandom_range(65, 127));
                default: len_cfg = 7'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 3))
                0: offset = '0;
                1: offset = {{32{1'b0}}, $urandom} - 64'h8000_0000;
                2: offset = {$urandom, $urandom};
                default: offset = ($urandom_range(0, 1) == 1) ? PHYS_MAX : PHYS_MIN;
            endcase
            configure(6'($urandom_range(0, 63)), len_cfg, t_order'($urandom_range(0, 1)),
                      random_q16(), offset, random_q16());
            fmax = field_mask((sig_length > 7'd64) ? 64 : sig_length);

            for (int k = 0; k < REQUESTS_PER_SETTING; k++) begin
                cmd     = t_cmd'($urandom_range(0, 1));
                payload = {$urandom, $urandom};
                span    = {$urandom, $urandom};
                case ($urandom_range(0, 15))
                    0: payload = '0;
                    1: payload = '1;
                    default: ;
                endcase
                // Aim half the encodes at the field, with a random fraction below the point.
                case ($urandom_range(0, 3))
                    0, 1: phys = sig_offset + ((span & fmax) << 16) + $urandom_range(0, 65535);
                    2: begin
                        span = span >> $urandom_range(0, 63);
                        phys = ($urandom_range(0, 1) == 1) ? sig_offset - span : sig_offset + span;
                    end
                    default: phys = span;
                endcase
                send_request(cmd, payload, phys);
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        // Hold reset, then release it away from the sampling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_intel_layout();
        test_motorola_layout();
        test_decode_saturation();
        test_encode_clamp();
        test_length_edges();
        test_random_traffic();
        wait_for_results();

        $display("Ran %0d decode and %0d encode requests across %0d register settings,",
                 n_decode, n_encode, n_settings);
        $display("%0d of them saturated or clamped; %0d field mismatches seen.",
                 n_flagged, mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> can_signal_extract_pack.f
+incdir+hw/rtl
hw/rtl/cse_pkg.sv
hw/rtl/cse_mul.sv
hw/rtl/can_signal_extract_pack.sv
test/testbench.sv
